FILE: rtl/core/slem_pkg.sv
// Shared types and constants for the scheduler latency and event monitor.
`default_nettype none

package slem_pkg;

   // Request action codes
   localparam logic [2:0] ACT_LATENCY = 3'd0;
   localparam logic [2:0] ACT_SWITCH  = 3'd1;
   localparam logic [2:0] ACT_EVENT   = 3'd2;
   localparam logic [2:0] ACT_CLEAR   = 3'd3;
   localparam logic [2:0] ACT_READ    = 3'd4;

   // Task event counters
   localparam int unsigned NUM_EVENTS = 7;
   localparam logic [2:0] EVT_INVERSION = 3'd4;
   localparam logic [2:0] EVT_MISS      = 3'd5;
   localparam logic [2:0] EVT_MET       = 3'd6;

   // Statistic select codes
   localparam logic [3:0] STAT_COUNT      = 4'd0;
   localparam logic [3:0] STAT_TOTAL      = 4'd1;
   localparam logic [3:0] STAT_MIN        = 4'd2;
   localparam logic [3:0] STAT_MAX        = 4'd3;
   localparam logic [3:0] STAT_AVERAGE    = 4'd4;
   localparam logic [3:0] STAT_SWITCH     = 4'd5;
   localparam logic [3:0] STAT_EVENT_BASE = 4'd6;
   localparam logic [3:0] STAT_EVENT_LAST = 4'd12;

   // CSR map
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAT_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAT_MID   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISS_LIM  = 3'd3;

   localparam logic [31:0] LAT_HIGH_RESET  = 32'd10000;
   localparam logic [31:0] LAT_MID_RESET   = 32'd5000;
   localparam logic [31:0] INV_LIMIT_RESET = 32'd10;
   localparam logic [6:0]  MISS_LIM_RESET  = 7'd50;

   // Health score
   localparam logic signed [9:0] SCORE_FULL      = 10'sd100;
   localparam logic signed [9:0] PEN_LAT_HIGH    = 10'sd20;
   localparam logic signed [9:0] PEN_LAT_MID     = 10'sd10;
   localparam logic signed [9:0] PEN_INV_HIGH    = 10'sd15;
   localparam logic signed [9:0] PEN_INV_LOW     = 10'sd5;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Shared divider
   localparam int unsigned DIV_WIDTH     = 64;
   localparam int unsigned DIV_CNT_WIDTH = $clog2(DIV_WIDTH);

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] latency_ns;
      logic [2:0]  event_code;
      logic [3:0]  stat_index;
   } cmd_type;

   typedef struct packed {
      logic [31:0] lat_high;
      logic [31:0] lat_mid;
      logic [31:0] inv_limit;
      logic [6:0]  miss_limit;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [DIV_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/scheduler_latency_event_monitor.sv
// Top level of the scheduler latency and event monitor.
//
//   channel  direction  handshake                 payload
//   request  in         push / full               req_action, req_latency_ns,
//                                                 req_event_code, req_stat_index
//   result   out        empty / pop               rsp_read_data, rsp_health_score
//   csr      in         valid / ready (always 1)  csr_index, csr_data
//
// Record, switch, event and clear requests retire at one per cycle while no read is in progress.
// A read runs the shared divider for the live average and then the miss rate; the average
// is skipped if no latency is recorded, the rate if misses or misses plus mets are zero.
// Reset is synchronous; there is no clearing pass.
// A two-entry command queue lets intake continue while a read runs, and the
// result register lets the back end finish a read while the consumer stalls.
`default_nettype none

module scheduler_latency_event_monitor import slem_pkg::*; #(
   parameter int unsigned COUNTER_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [2:0]                 req_action,
   input  wire logic [31:0]                req_latency_ns,
   input  wire logic [3:0]                 req_event_code,
   input  wire logic [3:0]                 req_stat_index,
   // result channel
   output logic                            empty,
   input  wire logic                       pop,
   output logic [63:0]                     rsp_read_data,
   output logic [6:0]                      rsp_health_score,
   // csr write channel
   input  wire logic                       valid,
   output logic                            ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                csr_data
);

   cfg_type     cfg_ff, cfg_in;
   cmd_type     cmd;
   logic        cmd_valid;
   logic        cmd_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        csr_write;

   // csr writes never stall; user must change limits only while idle, not enforced here
   assign ready     = 1'b1;
   assign csr_write = valid && ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LAT_HIGH:  cfg_in.lat_high   = csr_data;
            CSR_LAT_MID:   cfg_in.lat_mid    = csr_data;
            CSR_INV_LIMIT: cfg_in.inv_limit  = csr_data;
            CSR_MISS_LIM:  cfg_in.miss_limit = csr_data[6:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lat_high   <= LAT_HIGH_RESET;
         cfg_ff.lat_mid    <= LAT_MID_RESET;
         cfg_ff.inv_limit  <= INV_LIMIT_RESET;
         cfg_ff.miss_limit <= MISS_LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, filter no-op requests, queue commands
   slem_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_latency_ns (req_latency_ns),
      .req_event_code (req_event_code),
      .req_stat_index (req_stat_index),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // back: statistics, read sequencing, scoring and result register
   slem_back #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .cfg              (cfg_ff),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .empty            (empty),
      .pop              (pop),
      .rsp_read_data    (rsp_read_data),
      .rsp_health_score (rsp_health_score)
   );

   // shared divider for the average and the miss rate
   slem_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

`default_nettype wire

FILE: rtl/core/slem_front.sv
// Front end: request intake, action filtering and the command queue.
`default_nettype none

module slem_front import slem_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_latency_ns,
   input  wire logic [3:0]  req_event_code,
   input  wire logic [3:0]  req_stat_index,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  wire logic        cmd_pop
);

   cmd_type                q_ff [QUEUE_DEPTH];
   cmd_type                cmd_in;
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   accept;
   logic                   useful;
   logic                   enq;
   logic                   deq;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;

   // unknown actions and unknown event codes are dropped here
   always_comb begin
      priority if (req_action > ACT_READ) begin
         useful = 1'b0;
      end else if (req_action == ACT_EVENT) begin
         useful = (req_event_code < 4'(NUM_EVENTS));
      end else begin
         useful = 1'b1;
      end
   end

   always_comb begin
      cmd_in.op         = req_action;
      cmd_in.latency_ns = req_latency_ns;
      cmd_in.event_code = req_event_code[2:0];
      cmd_in.stat_index = req_stat_index;
   end

   assign enq = accept && useful;
   assign deq = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/slem_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module slem_divider import slem_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]     quo_ff, quo_in;
   logic [DIV_WIDTH-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_WIDTH:0]       shifted;
   logic                     ge;

   // partial remainder stays below the divisor, so the difference fits
   assign shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign ge      = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_WIDTH'(shifted - {1'b0, dsr_ff}) : shifted[DIV_WIDTH-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(DIV_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/slem_back.sv
// Back end: statistics registers, read sequencing, health score, result register.
`default_nettype none

module slem_back import slem_pkg::*; #(
   parameter int unsigned COUNTER_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  cfg_type     cfg,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        empty,
   input  wire logic   pop,
   output logic [63:0] rsp_read_data,
   output logic [6:0]  rsp_health_score
);

   localparam int unsigned CW = COUNTER_WIDTH;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_AVG_WAIT  = 2'd1;
   localparam logic [1:0] ST_RATE_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT       = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [63:0]   total_ff, total_in;
   logic [31:0]   min_ff, min_in;
   logic [31:0]   max_ff, max_in;
   logic [CW-1:0] switch_ff, switch_in;
   logic [CW-1:0] evt_ff [NUM_EVENTS];
   logic [CW-1:0] evt_in [NUM_EVENTS];
   logic [3:0]    idx_ff, idx_in;
   logic [31:0]   avg_ff, avg_in;
   logic [63:0]   rate_ff, rate_in;
   logic          rate_used_ff, rate_used_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic [6:0]    rsp_score_ff, rsp_score_in;

   logic          rsp_pop;
   logic          rsp_load;
   logic          start_avg;
   logic          start_rate;
   logic          rate_ok;
   logic [CW-1:0] miss_met_sum;
   logic [63:0]   miss_x100;
   logic [63:0]   read_value;
   logic [2:0]    evt_sel;
   logic signed [9:0] score;

   assign rsp_pop  = pop && rsp_valid_ff;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_pop);
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   // miss rate operands: sum wraps at counter width, product at 64 bits
   assign miss_met_sum = evt_ff[EVT_MISS] + evt_ff[EVT_MET];
   assign miss_x100    = (64'(evt_ff[EVT_MISS]) << 6) + (64'(evt_ff[EVT_MISS]) << 5)
                         + (64'(evt_ff[EVT_MISS]) << 2);
   assign rate_ok      = (evt_ff[EVT_MISS] != '0) && (miss_met_sum != '0);

   assign div_req.start    = start_avg || start_rate;
   assign div_req.dividend = start_rate ? miss_x100 : total_ff;
   assign div_req.divisor  = start_rate ? 64'(miss_met_sum) : 64'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      switch_in    = switch_ff;
      evt_in       = evt_ff;
      idx_in       = idx_ff;
      avg_in       = avg_ff;
      rate_in      = rate_ff;
      rate_used_in = rate_used_ff;
      start_avg    = 1'b0;
      start_rate   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  ACT_LATENCY: begin
                     count_in = count_ff + CW'(1);
                     total_in = total_ff + 64'(cmd.latency_ns);
                     if ((cmd.latency_ns < min_ff) || (min_ff == '0)) begin
                        min_in = cmd.latency_ns;
                     end
                     if (cmd.latency_ns > max_ff) begin
                        max_in = cmd.latency_ns;
                     end
                  end
                  ACT_SWITCH: begin
                     switch_in = switch_ff + CW'(1);
                  end
                  ACT_EVENT: begin
                     for (int i = 0; i < NUM_EVENTS; i++) begin
                        if (cmd.event_code == 3'(i)) begin
                           evt_in[i] = evt_ff[i] + CW'(1);
                        end
                     end
                  end
                  ACT_CLEAR: begin
                     count_in  = '0;
                     total_in  = '0;
                     min_in    = '0;
                     max_in    = '0;
                     switch_in = '0;
                     for (int i = 0; i < NUM_EVENTS; i++) begin
                        evt_in[i] = '0;
                     end
                  end
                  ACT_READ: begin
                     idx_in = cmd.stat_index;
                     if (count_ff != '0) begin
                        start_avg = 1'b1;
                        state_in  = ST_AVG_WAIT;
                     end else begin
                        avg_in = '0;
                        if (rate_ok) begin
                           start_rate = 1'b1;
                           state_in   = ST_RATE_WAIT;
                        end else begin
                           rate_used_in = 1'b0;
                           state_in     = ST_OUT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_AVG_WAIT: begin
            if (div_rsp.done) begin
               avg_in = div_rsp.quotient[31:0];
               if (rate_ok) begin
                  start_rate = 1'b1;
                  state_in   = ST_RATE_WAIT;
               end else begin
                  rate_used_in = 1'b0;
                  state_in     = ST_OUT;
               end
            end
         end
         ST_RATE_WAIT: begin
            if (div_rsp.done) begin
               rate_in      = div_rsp.quotient;
               rate_used_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // selected statistic
   assign evt_sel = 3'(idx_ff - STAT_EVENT_BASE);

   always_comb begin
      unique case (idx_ff)
         STAT_COUNT:   read_value = 64'(count_ff);
         STAT_TOTAL:   read_value = total_ff;
         STAT_MIN:     read_value = 64'(min_ff);
         STAT_MAX:     read_value = 64'(max_ff);
         STAT_AVERAGE: read_value = 64'(avg_ff);
         STAT_SWITCH:  read_value = 64'(switch_ff);
         default: begin
            if ((idx_ff >= STAT_EVENT_BASE) && (idx_ff <= STAT_EVENT_LAST)) begin
               read_value = 64'(evt_ff[evt_sel]);
            end else begin
               read_value = '0;
            end
         end
      endcase
   end

   // health score; a rate within the limit is at most 127
   always_comb begin
      score = SCORE_FULL;
      if (rate_used_ff) begin
         if (rate_ff > 64'(cfg.miss_limit)) begin
            score = '0;
         end else begin
            score = SCORE_FULL - $signed({2'b00, rate_ff[6:0], 1'b0});
         end
      end
      if (avg_ff > cfg.lat_high) begin
         score = score - PEN_LAT_HIGH;
      end else if (avg_ff > cfg.lat_mid) begin
         score = score - PEN_LAT_MID;
      end
      if (64'(evt_ff[EVT_INVERSION]) > 64'(cfg.inv_limit)) begin
         score = score - PEN_INV_HIGH;
      end else if (evt_ff[EVT_INVERSION] != '0) begin
         score = score - PEN_INV_LOW;
      end
      if (score < 0) begin
         score = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_score_in = rsp_score_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = read_value;
         rsp_score_in = score[6:0];
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         switch_ff    <= '0;
         evt_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         switch_ff    <= switch_in;
         evt_ff       <= evt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      avg_ff       <= avg_in;
      rate_ff      <= rate_in;
      rate_used_ff <= rate_used_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign empty            = !rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_health_score = rsp_score_ff;

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_wait_has_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AVG_WAIT || state_ff == ST_RATE_WAIT) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on an idle divider");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !pop) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result lost or changed");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result appeared outside the output step");
`endif

endmodule

`default_nettype wire
